### rtl/core/anbx_pkg.sv
// ----------------------------------------------------------------------------
// Annex-B NAL unit indexer package
// Shared types, constants and decode functions of the NAL unit indexer.
// ----------------------------------------------------------------------------
package anbx_pkg;

	localparam int POSITION_BITS_DEF    = 48;
	localparam int FRAME_COUNT_BITS_DEF = 32;

	localparam int DATA_BITS   = 8;
	localparam int OFFSET_BITS = 48;
	localparam int SIZE_BITS   = 48;
	localparam int TYPE_BITS   = 6;
	localparam int KIND_BITS   = 2;
	localparam int NUMBER_BITS = 32;

	localparam int QUEUE_DEPTH = 2;

	localparam logic CODEC_H264 = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	localparam logic [TYPE_BITS-1:0] TYPE_MASK_H264 = 6'h1F;
	localparam logic [TYPE_BITS-1:0] TYPE_MASK_H265 = 6'h3F;

	localparam logic [DATA_BITS-1:0] START_CODE_END = 8'h01;
	localparam logic [DATA_BITS-1:0] ZERO_BYTE      = 8'h00;
	localparam logic [1:0]           ZERO_RUN_MAX   = 2'd2;

	localparam logic [TYPE_BITS-1:0] H264_NON_IDR_SLICE = 6'd1;
	localparam logic [TYPE_BITS-1:0] H264_IDR_SLICE     = 6'd5;
	localparam logic [TYPE_BITS-1:0] H265_LAST_VCL      = 6'd21;
	localparam logic [TYPE_BITS-1:0] H265_FIRST_IRAP    = 6'd19;
	localparam logic [TYPE_BITS-1:0] H265_FIRST_P       = 6'd1;
	localparam logic [TYPE_BITS-1:0] H265_LAST_P        = 6'd9;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_I = 2'd0,
		KIND_P = 2'd1,
		KIND_B = 2'd2
	} frame_kind_t;

	typedef struct packed {
		logic                 header;
		logic                 start;
		logic                 eos;
		logic [TYPE_BITS-1:0] unit_type;
	} anbx_event_t;

	function automatic logic unit_decodable(input logic codec,
			input logic [TYPE_BITS-1:0] t);
		logic ok;
		if (codec == CODEC_H264) begin
			ok = (t == H264_NON_IDR_SLICE) || (t == H264_IDR_SLICE);
		end else begin
			ok = (t <= H265_LAST_VCL);
		end
		return ok;
	endfunction

	function automatic frame_kind_t unit_kind(input logic codec,
			input logic [TYPE_BITS-1:0] t);
		frame_kind_t k;
		if (codec == CODEC_H264) begin
			k = (t == H264_IDR_SLICE) ? KIND_I : KIND_P;
		end else if (t >= H265_FIRST_IRAP && t <= H265_LAST_VCL) begin
			k = KIND_I;
		end else if (t >= H265_FIRST_P && t <= H265_LAST_P) begin
			k = KIND_P;
		end else begin
			k = KIND_B;
		end
		return k;
	endfunction

endpackage

### rtl/core/anbx_if.sv
// ----------------------------------------------------------------------------
// Annex-B NAL unit indexer channels
// Valid/ready channels for the incoming byte stream and the unit records.
// ----------------------------------------------------------------------------
interface anbx_byte_if;
	logic                           valid;
	logic                           ready;
	logic [anbx_pkg::DATA_BITS-1:0] data_byte;
	logic                           end_of_stream;

	modport source(output valid, output data_byte, output end_of_stream, input ready);
	modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface anbx_unit_if;
	logic                             valid;
	logic                             ready;
	logic [anbx_pkg::OFFSET_BITS-1:0] unit_offset;
	logic [anbx_pkg::SIZE_BITS-1:0]   unit_size;
	logic [anbx_pkg::TYPE_BITS-1:0]   unit_type;
	logic [anbx_pkg::KIND_BITS-1:0]   frame_kind;
	logic [anbx_pkg::NUMBER_BITS-1:0] frame_number;

	modport source(output valid, output unit_offset, output unit_size, output unit_type,
		output frame_kind, output frame_number, input ready);
	modport sink(input valid, input unit_offset, input unit_size, input unit_type,
		input frame_kind, input frame_number, output ready);
endinterface

### rtl/core/anbx_queue.sv
// ----------------------------------------------------------------------------
// Event queue
// Small register queue that decouples the byte classifier from the record
// builder.
// ----------------------------------------------------------------------------
module anbx_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int DEPTH      = anbx_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]      entries_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [COUNT_BITS-1:0] count_q;

	assign full     = (count_q == COUNT_BITS'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### rtl/core/anbx_front.sv
// ----------------------------------------------------------------------------
// Byte classifier
// Accepts stream bytes, finds start codes and header bytes, tracks the byte
// position and queues an event for every byte that matters to the units.
// ----------------------------------------------------------------------------
module anbx_front #(
	parameter int POSITION_BITS = anbx_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     codec_select,
	anbx_byte_if.sink                stream,
	input  logic                     q_full,
	output logic                     ev_push,
	output anbx_pkg::anbx_event_t    ev,
	output logic [POSITION_BITS-1:0] ev_pos
);
	logic [1:0]               zero_run_q;
	logic                     header_pending_q;
	logic [POSITION_BITS-1:0] pos_q;

	logic                     accept;
	logic                     is_zero;
	logic                     is_start;
	logic [POSITION_BITS-1:0] pos_next;
	logic [POSITION_BITS-1:0] new_start;

	assign stream.ready = !q_full;
	assign accept       = stream.valid && stream.ready;

	always_comb begin
		is_zero   = (stream.data_byte == anbx_pkg::ZERO_BYTE);
		is_start  = !header_pending_q && (stream.data_byte == anbx_pkg::START_CODE_END)
			&& (zero_run_q == anbx_pkg::ZERO_RUN_MAX);
		pos_next  = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
		new_start = (pos_q >= POSITION_BITS'(2)) ? pos_q - POSITION_BITS'(2) : '0;

		ev.header = header_pending_q;
		ev.start  = is_start;
		ev.eos    = stream.end_of_stream;
		if (codec_select == anbx_pkg::CODEC_H265) begin
			ev.unit_type = stream.data_byte[6:1] & anbx_pkg::TYPE_MASK_H265;
		end else begin
			ev.unit_type = stream.data_byte[5:0] & anbx_pkg::TYPE_MASK_H264;
		end
		ev_pos  = is_start ? new_start : pos_next;
		ev_push = accept && (header_pending_q || is_start || stream.end_of_stream);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q       <= '0;
			header_pending_q <= 1'b0;
			pos_q            <= '0;
		end else if (accept) begin
			if (stream.end_of_stream) begin
				zero_run_q       <= '0;
				header_pending_q <= 1'b0;
				pos_q            <= '0;
			end else begin
				pos_q            <= pos_next;
				header_pending_q <= is_start;
				if (!header_pending_q && is_zero) begin
					zero_run_q <= (zero_run_q == anbx_pkg::ZERO_RUN_MAX) ?
						zero_run_q : zero_run_q + 1'b1;
				end else begin
					zero_run_q <= '0;
				end
			end
		end
	end
endmodule

### rtl/core/anbx_back.sv
// ----------------------------------------------------------------------------
// Record builder
// Takes queued events, keeps the open unit and builds a record into the
// output register whenever a decodable unit closes.
// ----------------------------------------------------------------------------
module anbx_back #(
	parameter int POSITION_BITS    = anbx_pkg::POSITION_BITS_DEF,
	parameter int FRAME_COUNT_BITS = anbx_pkg::FRAME_COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     codec_select,
	input  logic                     ev_valid,
	input  anbx_pkg::anbx_event_t    ev,
	input  logic [POSITION_BITS-1:0] ev_pos,
	output logic                     ev_pop,
	anbx_unit_if.source              units
);
	localparam int PosExtBits   = (POSITION_BITS > anbx_pkg::OFFSET_BITS) ?
		POSITION_BITS : anbx_pkg::OFFSET_BITS;
	localparam int FrameExtBits = (FRAME_COUNT_BITS > anbx_pkg::NUMBER_BITS) ?
		FRAME_COUNT_BITS : anbx_pkg::NUMBER_BITS;

	logic [POSITION_BITS-1:0]         start_q;
	logic [anbx_pkg::TYPE_BITS-1:0]   type_q;
	logic                             open_q;
	logic [FRAME_COUNT_BITS-1:0]      frames_q;

	logic                             out_valid_q;
	logic [anbx_pkg::OFFSET_BITS-1:0] offset_q;
	logic [anbx_pkg::SIZE_BITS-1:0]   size_q;
	logic [anbx_pkg::TYPE_BITS-1:0]   out_type_q;
	anbx_pkg::frame_kind_t            kind_q;
	logic [anbx_pkg::NUMBER_BITS-1:0] number_q;

	logic                             open_now;
	logic [anbx_pkg::TYPE_BITS-1:0]   type_now;
	logic                             emit;
	logic [POSITION_BITS-1:0]         size;
	logic [PosExtBits-1:0]            start_ext;
	logic [PosExtBits-1:0]            size_ext;
	logic [FrameExtBits-1:0]          frames_ext;

	assign ev_pop = ev_valid && (!out_valid_q || units.ready);

	always_comb begin
		open_now   = ev.header || open_q;
		type_now   = ev.header ? ev.unit_type : type_q;
		emit       = (ev.start || ev.eos) && open_now
			&& anbx_pkg::unit_decodable(codec_select, type_now);
		size       = (ev_pos >= start_q) ? ev_pos - start_q : '0;
		start_ext  = PosExtBits'(start_q);
		size_ext   = PosExtBits'(size);
		frames_ext = FrameExtBits'(frames_q);
	end

	always_ff @(posedge clk) begin
		if (ev_pop && emit) begin
			offset_q   <= start_ext[anbx_pkg::OFFSET_BITS-1:0];
			size_q     <= size_ext[anbx_pkg::SIZE_BITS-1:0];
			out_type_q <= type_now;
			kind_q     <= anbx_pkg::unit_kind(codec_select, type_now);
			number_q   <= frames_ext[anbx_pkg::NUMBER_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			start_q     <= '0;
			type_q      <= '0;
			open_q      <= 1'b0;
			frames_q    <= '0;
		end else begin
			if (ev_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (units.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ev_pop) begin
				if (ev.eos) begin
					start_q  <= '0;
					type_q   <= '0;
					open_q   <= 1'b0;
					frames_q <= '0;
				end else if (ev.start) begin
					start_q  <= ev_pos;
					open_q   <= 1'b0;
					frames_q <= emit ? frames_q + FRAME_COUNT_BITS'(1) : frames_q;
				end else begin
					type_q <= ev.unit_type;
					open_q <= 1'b1;
				end
			end
		end
	end

	assign units.valid        = out_valid_q;
	assign units.unit_offset  = offset_q;
	assign units.unit_size    = size_q;
	assign units.unit_type    = out_type_q;
	assign units.frame_kind   = kind_q;
	assign units.frame_number = number_q;
endmodule

### rtl/core/annexb_nal_unit_indexer.sv
// ----------------------------------------------------------------------------
// Annex-B NAL unit indexer
// Finds start codes in an H.264 or H.265 byte stream and reports one record
// per decodable NAL unit.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle and keeps that rate for
// as long as the record sink takes records; a record reaches the sink
// through the event queue and the output register. A two-entry event
// queue between the byte classifier and the record builder absorbs short
// stalls of the sink, and the byte input stalls only once that queue is
// full. Set codec_select only while the block is idle.
module annexb_nal_unit_indexer #(
	parameter int POSITION_BITS    = anbx_pkg::POSITION_BITS_DEF,
	parameter int FRAME_COUNT_BITS = anbx_pkg::FRAME_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	anbx_byte_if.sink   stream,
	anbx_unit_if.source units
);
	localparam int EventBits = $bits(anbx_pkg::anbx_event_t) + POSITION_BITS;

	logic                     codec_q;
	logic                     ev_push;
	anbx_pkg::anbx_event_t    front_ev;
	logic [POSITION_BITS-1:0] front_pos;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic [EventBits-1:0]     q_data;
	anbx_pkg::anbx_event_t    back_ev;
	logic [POSITION_BITS-1:0] back_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= anbx_pkg::CODEC_H264;
		end else if (cfg_write_en) begin
			codec_q <= cfg_write_data;
		end
	end

	anbx_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.codec_select(codec_q),
		.stream      (stream),
		.q_full      (q_full),
		.ev_push     (ev_push),
		.ev          (front_ev),
		.ev_pos      (front_pos)
	);

	anbx_queue #(
		.WIDTH(EventBits)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ev_push),
		.push_data({front_ev, front_pos}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	assign {back_ev, back_pos} = q_data;

	anbx_back #(
		.POSITION_BITS   (POSITION_BITS),
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.codec_select(codec_q),
		.ev_valid    (!q_empty),
		.ev          (back_ev),
		.ev_pos      (back_pos),
		.ev_pop      (q_pop),
		.units       (units)
	);

	// An event is never pushed into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) ev_push |-> !q_full)
		else $error("event pushed into a full queue");

	// The record builder only takes events that are present.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("event taken from an empty queue");

	// Under H.264 rules only slice units are reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		(units.valid && codec_q == anbx_pkg::CODEC_H264) |->
		(units.unit_type == anbx_pkg::H264_NON_IDR_SLICE ||
		units.unit_type == anbx_pkg::H264_IDR_SLICE))
		else $error("non-slice unit reported under H.264 rules");
endmodule
